>>> hw/rtl/pors_pkg.sv
// shared types, constants and saturating arithmetic for the piezo offset ramp sequencer
package pors_pkg;

  // position width and the width of an exact position plus increment sum
  localparam int POS_BITS  = 32;
  localparam int SUM_BITS  = ((POS_BITS > 32) ? POS_BITS : 32) + 1;
  localparam int VAL_BITS  = 32;
  localparam int CNT_BITS  = 31;
  localparam int FLAG_BITS = 4;
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  // mode flag bit positions
  localparam int FLAG_XY    = 0;
  localparam int FLAG_DRIFT = 1;
  localparam int FLAG_ZRAMP = 2;
  localparam int FLAG_ZAUTO = 3;

  // item mode codes
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_START = 1'b1;

  // feedback thresholds and increment limits
  localparam logic signed [VAL_BITS-1:0] FB_ABORT_LIMIT = -32'sd15000;
  localparam logic signed [VAL_BITS-1:0] FB_AUTO_PIVOT  = 32'sd2500;
  localparam logic signed [VAL_BITS-1:0] FB_DONE_LIMIT  = 32'sd5000;
  localparam logic signed [VAL_BITS-1:0] VAL_ZERO       = 32'sd0;
  localparam logic signed [VAL_BITS-1:0] VAL_MAX        = 32'sh7fff_ffff;
  localparam logic signed [VAL_BITS-1:0] VAL_MIN        = 32'sh8000_0000;

  // position limits, extended to the sum width
  localparam logic signed [SUM_BITS-1:0] POS_MAX_S =
    (SUM_BITS'(1) <<< (POS_BITS - 1)) - SUM_BITS'(1);
  localparam logic signed [SUM_BITS-1:0] POS_MIN_S = -POS_MAX_S - SUM_BITS'(1);

  // register map
  typedef enum logic [2:0] {
    REG_START_FLAGS = 3'd0,
    REG_STEP_COUNT  = 3'd1,
    REG_STEP_X      = 3'd2,
    REG_STEP_Y      = 3'd3,
    REG_STEP_Z      = 3'd4,
    REG_TARGET_X    = 3'd5,
    REG_TARGET_Y    = 3'd6
  } reg_idx_t;

  typedef logic        [FLAG_BITS-1:0] flags_t;
  typedef logic        [CNT_BITS-1:0]  count_t;
  typedef logic signed [VAL_BITS-1:0]  val_t;
  typedef logic signed [POS_BITS-1:0]  pos_t;

  typedef struct packed {
    flags_t start_flags;
    count_t step_count;
    val_t   step_x;
    val_t   step_y;
    val_t   step_z;
    val_t   target_x;
    val_t   target_y;
  } cfg_t;

  typedef struct packed {
    logic mode;
    val_t feedback_z;
  } item_t;

  typedef struct packed {
    flags_t flags;
    count_t steps_left;
    count_t drift_wait;
    val_t   step_x;
    val_t   step_y;
    val_t   step_z;
    pos_t   pos_x;
    pos_t   pos_y;
    pos_t   pos_z;
  } state_t;

  // clamp an extended value into the position range
  function automatic pos_t clamp_pos(input logic signed [SUM_BITS-1:0] v);
    logic signed [SUM_BITS-1:0] c;
    if (v > POS_MAX_S) begin
      c = POS_MAX_S;
    end else if (v < POS_MIN_S) begin
      c = POS_MIN_S;
    end else begin
      c = v;
    end
    return POS_BITS'(c);
  endfunction

  // saturating position plus increment
  function automatic pos_t sat_add(input pos_t p, input val_t s);
    return clamp_pos(SUM_BITS'(p) + SUM_BITS'(s));
  endfunction

  // target value taken into the position range
  function automatic pos_t clamp_val(input val_t t);
    return clamp_pos(SUM_BITS'(t));
  endfunction

  // low 32 bits of the sign-extended position
  function automatic val_t pos_out(input pos_t p);
    logic signed [SUM_BITS-1:0] e;
    e = SUM_BITS'(p);
    return e[VAL_BITS-1:0];
  endfunction

endpackage

>>> hw/rtl/pors_if.sv
// item channel interfaces for the input and result sides

interface pors_in_if import pors_pkg::*; ();
  logic valid;
  logic ready;
  logic mode;
  val_t feedback_z;

  modport source (output valid, output mode, output feedback_z, input ready);
  modport sink   (input valid, input mode, input feedback_z, output ready);
endinterface

interface pors_out_if import pors_pkg::*; ();
  logic   valid;
  logic   ready;
  val_t   pos_x;
  val_t   pos_y;
  val_t   pos_z;
  flags_t active_flags;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output active_flags, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input active_flags, output ready);
endinterface

>>> hw/rtl/pors_cfg_regs.sv
// apb configuration registers
module pors_cfg_regs import pors_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_START_FLAGS: cfg_r.start_flags <= pwdata[FLAG_BITS-1:0];
        REG_STEP_COUNT:  cfg_r.step_count  <= pwdata[CNT_BITS-1:0];
        REG_STEP_X:      cfg_r.step_x      <= pwdata;
        REG_STEP_Y:      cfg_r.step_y      <= pwdata;
        REG_STEP_Z:      cfg_r.step_z      <= pwdata;
        REG_TARGET_X:    cfg_r.target_x    <= pwdata;
        REG_TARGET_Y:    cfg_r.target_y    <= pwdata;
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (idx)
      REG_START_FLAGS: prdata = DATA_BITS'(cfg_r.start_flags);
      REG_STEP_COUNT:  prdata = DATA_BITS'(cfg_r.step_count);
      REG_STEP_X:      prdata = cfg_r.step_x;
      REG_STEP_Y:      prdata = cfg_r.step_y;
      REG_STEP_Z:      prdata = cfg_r.step_z;
      REG_TARGET_X:    prdata = cfg_r.target_x;
      REG_TARGET_Y:    prdata = cfg_r.target_y;
      default:         prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/pors_in_reg.sv
// input item register with pass-through of the downstream stall
module pors_in_reg import pors_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  pors_in_if.sink      in_ch,
  input  logic         adv,
  output logic         itm_valid,
  output item_t        itm
);

  logic  valid_r;
  item_t itm_r;

  // take a new item whenever the held one moves on or none is held
  assign in_ch.ready = !valid_r || adv;
  assign itm_valid   = valid_r;
  assign itm         = itm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      itm_r.mode       <= in_ch.mode;
      itm_r.feedback_z <= in_ch.feedback_z;
    end
  end

endmodule

>>> hw/rtl/pors_tick_logic.sv
// next-state logic for one start or tick item
module pors_tick_logic import pors_pkg::*; (
  input  state_t state,
  input  item_t  itm,
  input  cfg_t   cfg,
  output state_t state_nxt
);

  val_t z_mag;
  val_t z_auto_step;
  logic fb_abort;
  logic fb_done;

  // auto-adjust increment: magnitude saturated, sign steered by feedback
  always_comb begin
    if (state.step_z > VAL_ZERO) begin
      z_mag = state.step_z;
    end else if (state.step_z == VAL_MIN) begin
      z_mag = VAL_MAX;
    end else begin
      z_mag = -state.step_z;
    end
    if (itm.feedback_z > FB_AUTO_PIVOT) begin
      z_auto_step = z_mag;
    end else if (state.step_z > VAL_ZERO) begin
      z_auto_step = -state.step_z;
    end else begin
      z_auto_step = state.step_z;
    end
  end

  assign fb_abort = (state.step_z > VAL_ZERO) && (itm.feedback_z < FB_ABORT_LIMIT);
  assign fb_done  = (itm.feedback_z < FB_DONE_LIMIT) && (itm.feedback_z > VAL_ZERO);

  always_comb begin
    state_nxt = state;
    if (itm.mode == MODE_START) begin
      // start: load flags, steps and increments, positions kept
      state_nxt.flags      = cfg.start_flags;
      state_nxt.steps_left = cfg.step_count;
      state_nxt.step_x     = cfg.step_x;
      state_nxt.step_y     = cfg.step_y;
      state_nxt.step_z     = cfg.step_z;
    end else begin
      // xy ramp, or else drift compensation
      if (state.flags[FLAG_XY]) begin
        if (state.steps_left != '0) begin
          state_nxt.pos_x      = sat_add(state.pos_x, state.step_x);
          state_nxt.pos_y      = sat_add(state.pos_y, state.step_y);
          state_nxt.steps_left = state.steps_left - CNT_BITS'(1);
        end else begin
          state_nxt.flags = '0;
          state_nxt.pos_x = clamp_val(cfg.target_x);
          state_nxt.pos_y = clamp_val(cfg.target_y);
        end
      end else if (state.flags[FLAG_DRIFT]) begin
        if (state.drift_wait != '0) begin
          state_nxt.drift_wait = state.drift_wait - CNT_BITS'(1);
        end else begin
          state_nxt.drift_wait = state.steps_left;
          state_nxt.pos_x      = sat_add(state.pos_x, state.step_x);
          state_nxt.pos_y      = sat_add(state.pos_y, state.step_y);
          state_nxt.pos_z      = sat_add(state.pos_z, state.step_z);
        end
      end

      // z ramp, or else z auto adjust, on what the xy part left
      if (state_nxt.flags[FLAG_ZRAMP]) begin
        if (state_nxt.steps_left != '0) begin
          if (fb_abort) begin
            state_nxt.step_z            = VAL_ZERO;
            state_nxt.flags[FLAG_ZRAMP] = 1'b0;
          end else begin
            state_nxt.pos_z = sat_add(state_nxt.pos_z, state.step_z);
          end
          state_nxt.steps_left = state_nxt.steps_left - CNT_BITS'(1);
        end else begin
          state_nxt.step_z            = VAL_ZERO;
          state_nxt.flags[FLAG_ZRAMP] = 1'b0;
        end
      end else if (state_nxt.flags[FLAG_ZAUTO]) begin
        if (state_nxt.steps_left != '0) begin
          if (fb_done) begin
            state_nxt.step_z            = VAL_ZERO;
            state_nxt.flags[FLAG_ZAUTO] = 1'b0;
          end else begin
            state_nxt.step_z = z_auto_step;
            state_nxt.pos_z  = sat_add(state_nxt.pos_z, z_auto_step);
          end
          state_nxt.steps_left = state_nxt.steps_left - CNT_BITS'(1);
        end else begin
          state_nxt.step_z            = VAL_ZERO;
          state_nxt.flags[FLAG_ZAUTO] = 1'b0;
        end
      end
    end
  end

endmodule

>>> hw/rtl/piezo_offset_ramp_sequencer_core.sv
// top level of the piezo offset ramp sequencer
// Takes one item per clock cycle while the result side does not stall. An
// accepted item is held in the input register; the position state and the result
// register are updated from it once the result register is free or being emptied,
// and the result is then offered from the result register.
// The rate is set by the state update (saturating adds and the feedback
// compares), which feeds back through the state register. The result register
// decouples the two sides: a new item is taken while a result waits. A start item
// (mode 1) loads flags, step count and increments from the registers; a tick item
// (mode 0) moves the positions. Registers sit at byte address 4*index on the APB
// port; write them only while no item is in flight.
module piezo_offset_ramp_sequencer_core import pors_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  pors_in_if.sink              in_ch,
  pors_out_if.source           out_ch,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  cfg_t   cfg;
  item_t  itm;
  logic   itm_valid;
  logic   adv;
  logic   fire;
  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  val_t   out_pos_x_r;
  val_t   out_pos_y_r;
  val_t   out_pos_z_r;
  flags_t out_flags_r;

  pors_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pors_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .adv       (adv),
    .itm_valid (itm_valid),
    .itm       (itm)
  );

  pors_tick_logic u_tick (
    .state     (state_r),
    .itm       (itm),
    .cfg       (cfg),
    .state_nxt (state_nxt)
  );

  // result register free or being emptied this cycle
  assign adv  = !out_valid_r || out_ch.ready;
  assign fire = itm_valid && adv;

  // position and mode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= itm_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_pos_x_r <= pos_out(state_nxt.pos_x);
      out_pos_y_r <= pos_out(state_nxt.pos_y);
      out_pos_z_r <= pos_out(state_nxt.pos_z);
      out_flags_r <= state_nxt.flags;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pos_x        = out_pos_x_r;
  assign out_ch.pos_y        = out_pos_y_r;
  assign out_ch.pos_z        = out_pos_z_r;
  assign out_ch.active_flags = out_flags_r;

endmodule

>>> hw/rtl/pors_checker.sv
// port-level assertions for the sequencer core and their binding
module pors_checker import pors_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input val_t   out_pos_x,
  input val_t   out_pos_y,
  input val_t   out_pos_z,
  input flags_t out_flags
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // a waiting result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pos_x) && $stable(out_pos_y) &&
                                $stable(out_pos_z) && $stable(out_flags))
    else $error("result payload changed while stalled");

  // with no result pending the input side is open
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // every accepted item is followed by an offered result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("accepted item produced no result");

endmodule

bind piezo_offset_ramp_sequencer_core pors_checker u_pors_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_pos_x (out_ch.pos_x),
  .out_pos_y (out_ch.pos_y),
  .out_pos_z (out_ch.pos_z),
  .out_flags (out_ch.active_flags)
);
